FILE: src/pspl_pkg.sv
// Shared types and constants for the positional PID speed loop.
// No dependencies; every other file of the block imports this package.
package pspl_pkg;

   // Field widths
   localparam int unsigned CountWidth = 8;
   localparam int unsigned GainWidth  = 24;
   localparam int unsigned BandWidth  = 8;
   localparam int unsigned DriveWidth = 16;
   localparam int unsigned ErrWidth   = 9;
   localparam int unsigned DerivWidth = 10;
   localparam int unsigned IntegWidth = 32;

   // Configuration port
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 24;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_GAIN_PROP  = 3'd0,
      CSR_GAIN_INTEG = 3'd1,
      CSR_GAIN_DERIV = 3'd2,
      CSR_DEAD_BAND  = 3'd3,
      CSR_OUT_MAX    = 3'd4
   } csr_index_type;

   // Register reset values
   localparam logic [GainWidth-1:0]  GainPropReset  = 24'd1966080;  // 30.0 in Q8.16
   localparam logic [GainWidth-1:0]  GainIntegReset = 24'd393;      // about 0.006
   localparam logic [GainWidth-1:0]  GainDerivReset = 24'd655360;   // 10.0
   localparam logic [BandWidth-1:0]  DeadBandReset  = 8'd2;
   localparam logic [DriveWidth-1:0] OutMaxReset    = 16'd2000;

endpackage : pspl_pkg

FILE: src/pspl_if.sv
// Valid/ready channel interfaces of the positional PID speed loop.
// Depends on pspl_pkg for field widths.

// Input beat: target and measured pulse counts
interface pspl_req_if;
   import pspl_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CountWidth-1:0] target;
   logic [CountWidth-1:0] measured;
   modport source (output valid, output target, output measured, input ready);
   modport sink   (input valid, input target, input measured, output ready);
endinterface : pspl_req_if

// Result beat: drive value
interface pspl_rsp_if;
   import pspl_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [DriveWidth-1:0] drive;
   modport source (output valid, output drive, input ready);
   modport sink   (input valid, input drive, output ready);
endinterface : pspl_rsp_if

// Register write beat: index and data
interface pspl_csr_if;
   import pspl_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [CsrIndexWidth-1:0] index;
   logic [CsrDataWidth-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface : pspl_csr_if

FILE: src/positional_pid_speed_loop.sv
// Top level of the positional PID speed loop: three-stage pipeline and registers.
// Depends on pspl_pkg and the channel interfaces in pspl_if.sv.

// Positional PID speed controller. Each input beat (target, measured) yields
// exactly one drive beat, in order. The pipeline has three register stages:
// input register, error/integral update, then the three gain multiplies with
// sum and clamp into the result register. One beat is taken every cycle
// while the result side keeps up; the multiply stage is the longest path.
// Any empty stage collapses, so up to two more input beats are taken while
// a finished result waits. Registers (index: name): 0 gain_prop,
// 1 gain_integ, 2 gain_deriv (unsigned Q8.16), 3 dead_band, 4 out_max;
// writes to other indexes are ignored, and writes are meant for when the
// block is idle.
module positional_pid_speed_loop (
   input  logic       clock,
   input  logic       reset,
   pspl_req_if.sink   req_ch,
   pspl_rsp_if.source rsp_ch,
   pspl_csr_if.sink   csr_ch
);
   import pspl_pkg::*;

   // Configuration registers
   logic [GainWidth-1:0]  gain_prop_ff,  gain_prop_in;
   logic [GainWidth-1:0]  gain_integ_ff, gain_integ_in;
   logic [GainWidth-1:0]  gain_deriv_ff, gain_deriv_in;
   logic [BandWidth-1:0]  dead_band_ff,  dead_band_in;
   logic [DriveWidth-1:0] out_max_ff,    out_max_in;

   // Pipeline valid bits and handshake
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic out_valid_ff, out_valid_in;
   logic out_move, s2_move, s1_move;
   logic req_beat, s1_adv, s2_adv;

   // Stage 1 payload
   logic [CountWidth-1:0] target_ff, target_in;
   logic [CountWidth-1:0] measured_ff, measured_in;

   // Loop state; it doubles as stage 2 error and integral operands
   logic signed [ErrWidth-1:0]   prev_err_ff, prev_err_in;
   logic signed [IntegWidth-1:0] integ_ff, integ_in;
   logic signed [DerivWidth-1:0] deriv_ff, deriv_in;

   // Result register
   logic [DriveWidth-1:0] drive_ff, drive_in;

   // Stage 1 combinational
   logic signed [ErrWidth-1:0]   err_raw;
   logic        [ErrWidth-1:0]   err_mag;
   logic signed [ErrWidth-1:0]   err_db;
   logic signed [IntegWidth:0]   integ_sum;
   logic signed [IntegWidth-1:0] integ_sat;
   logic signed [DerivWidth-1:0] deriv_new;

   // Stage 2 combinational
   logic signed [GainWidth:0]       gp_s, gi_s, gd_s;
   logic signed [GainWidth+ErrWidth:0]   prod_p;
   logic signed [GainWidth+IntegWidth:0] prod_i;
   logic signed [GainWidth+DerivWidth:0] prod_d;
   logic signed [GainWidth+IntegWidth+2:0] sum_all;
   logic [GainWidth+IntegWidth+2-16:0]     sum_whole;
   logic sum_pos, sum_over;

   // Handshake: each stage loads when it is empty or its contents move on
   assign out_move = !out_valid_ff || rsp_ch.ready;
   assign s2_move  = !s2_valid_ff || out_move;
   assign s1_move  = !s1_valid_ff || s2_move;
   assign req_ch.ready = s1_move;
   assign req_beat = req_ch.valid && s1_move;
   assign s1_adv   = s1_valid_ff && s2_move;
   assign s2_adv   = s2_valid_ff && out_move;

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.drive = drive_ff;
   assign csr_ch.ready = 1'b1;

   // Register writes
   always_comb begin
      gain_prop_in  = gain_prop_ff;
      gain_integ_in = gain_integ_ff;
      gain_deriv_in = gain_deriv_ff;
      dead_band_in  = dead_band_ff;
      out_max_in    = out_max_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_GAIN_PROP:  gain_prop_in  = csr_ch.data;
            CSR_GAIN_INTEG: gain_integ_in = csr_ch.data;
            CSR_GAIN_DERIV: gain_deriv_in = csr_ch.data;
            CSR_DEAD_BAND:  dead_band_in  = csr_ch.data[BandWidth-1:0];
            CSR_OUT_MAX:    out_max_in    = csr_ch.data[DriveWidth-1:0];
            default: ;
         endcase
      end
   end

   // Stage 1: error with dead band, saturating integral, derivative
   always_comb begin
      err_raw   = signed'({1'b0, target_ff}) - signed'({1'b0, measured_ff});
      err_mag   = err_raw[ErrWidth-1] ? ErrWidth'(-err_raw) : err_raw;
      err_db    = (err_mag <= {1'b0, dead_band_ff}) ? '0 : err_raw;
      integ_sum = (IntegWidth+1)'(integ_ff) + (IntegWidth+1)'(err_db);
      if (integ_sum[IntegWidth] != integ_sum[IntegWidth-1]) begin
         // overflow: clamp toward the sign of the true sum
         integ_sat = integ_sum[IntegWidth] ? {1'b1, {(IntegWidth-1){1'b0}}}
                                           : {1'b0, {(IntegWidth-1){1'b1}}};
      end else begin
         integ_sat = integ_sum[IntegWidth-1:0];
      end
      deriv_new = DerivWidth'(err_db) - DerivWidth'(prev_err_ff);
   end

   // Stage 2: gain products, Q.16 sum, truncate and clamp
   always_comb begin
      gp_s    = signed'({1'b0, gain_prop_ff});
      gi_s    = signed'({1'b0, gain_integ_ff});
      gd_s    = signed'({1'b0, gain_deriv_ff});
      prod_p  = gp_s * prev_err_ff;
      prod_i  = gi_s * integ_ff;
      prod_d  = gd_s * deriv_ff;
      sum_all = (GainWidth+IntegWidth+3)'(prod_p) + (GainWidth+IntegWidth+3)'(prod_i)
              + (GainWidth+IntegWidth+3)'(prod_d);
      sum_pos   = !sum_all[GainWidth+IntegWidth+2] && (|sum_all);
      sum_whole = sum_all[GainWidth+IntegWidth+2:16];
      sum_over  = sum_whole > ($bits(sum_whole))'(out_max_ff);
      if (!sum_pos) begin
         drive_in = '0;
      end else if (sum_over) begin
         drive_in = out_max_ff;
      end else begin
         drive_in = sum_whole[DriveWidth-1:0];
      end
   end

   // Next state of valids, payload and loop state
   always_comb begin
      s1_valid_in  = s1_move ? req_ch.valid : s1_valid_ff;
      s2_valid_in  = s2_move ? s1_valid_ff : s2_valid_ff;
      out_valid_in = out_move ? s2_valid_ff : out_valid_ff;
      target_in    = req_beat ? req_ch.target : target_ff;
      measured_in  = req_beat ? req_ch.measured : measured_ff;
      prev_err_in  = s1_adv ? err_db : prev_err_ff;
      integ_in     = s1_adv ? integ_sat : integ_ff;
      deriv_in     = s1_adv ? deriv_new : deriv_ff;
   end

   // Control state, configuration and loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         prev_err_ff   <= '0;
         integ_ff      <= '0;
         gain_prop_ff  <= GainPropReset;
         gain_integ_ff <= GainIntegReset;
         gain_deriv_ff <= GainDerivReset;
         dead_band_ff  <= DeadBandReset;
         out_max_ff    <= OutMaxReset;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         out_valid_ff  <= out_valid_in;
         prev_err_ff   <= prev_err_in;
         integ_ff      <= integ_in;
         gain_prop_ff  <= gain_prop_in;
         gain_integ_ff <= gain_integ_in;
         gain_deriv_ff <= gain_deriv_in;
         dead_band_ff  <= dead_band_in;
         out_max_ff    <= out_max_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      target_ff   <= target_in;
      measured_ff <= measured_in;
      deriv_ff    <= deriv_in;
      if (s2_adv) begin
         drive_ff <= drive_in;
      end
   end

endmodule : positional_pid_speed_loop

FILE: tb/tb_positional_pid_speed_loop.sv
// Self-checking testbench for positional_pid_speed_loop: directed table, then random phases.
// Needs pspl_pkg, the channel interfaces in pspl_if.sv and the top level of the block.
module tb_positional_pid_speed_loop;
   import pspl_pkg::*;

   localparam int NoCheck       = -1;     // table row checked against the PID model
   localparam int Phases        = 7;
   localparam int ItemsPerPhase = 250;
   localparam int ChokeCycles   = 150;    // long result-side hold-off
   localparam int TailCycles    = 10;
   localparam int CycleLimit    = 500000;
   localparam logic [CsrIndexWidth-1:0] CsrSpareLow  = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CsrSpareHigh = 3'd7;
   localparam longint IntegTop    = 2147483647;
   localparam longint IntegBottom = -IntegTop - 1;

   typedef struct {
      logic [CsrIndexWidth-1:0] idx;
      logic [CsrDataWidth-1:0]  data;
   } reg_write_type;

   typedef struct {
      bit                       is_reg;
      logic [CsrIndexWidth-1:0] idx;
      logic [CsrDataWidth-1:0]  data;
      logic [CountWidth-1:0]    tgt;
      logic [CountWidth-1:0]    meas;
      int                       drive;
   } dir_row_type;

   localparam int DirRowCount = 40;

   // Directed rows: register writes and beats; typed drives hold for the registers as last written
   dir_row_type dir_rows [DirRowCount] = '{
      '{1'b0, CSR_GAIN_PROP,  24'd0, 8'd0,   8'd0,   0},       // idle loop
      '{1'b0, CSR_GAIN_PROP,  24'd0, 8'd255, 8'd0,   2000},    // full error, clamped
      '{1'b0, CSR_GAIN_PROP,  24'd0, 8'd0,   8'd255, 0},       // negative sum
      '{1'b0, CSR_GAIN_PROP,  24'd0, 8'd2,   8'd0,   2000},    // in band, derivative only
      '{1'b0, CSR_GAIN_PROP,  24'd0, 8'd3,   8'd0,   120},     // just past the band
      '{1'b0, CSR_GAIN_PROP,  24'd0, 8'd0,   8'd3,   0},
      '{1'b0, CSR_GAIN_PROP,  24'd0, 8'd0,   8'd0,   30},      // derivative kick
      '{1'b0, CSR_GAIN_PROP,  24'd0, 8'd128, 8'd127, NoCheck},
      '{1'b1, CSR_OUT_MAX,    24'd0, 8'd0,   8'd0,   NoCheck}, // clamp at zero
      '{1'b0, CSR_GAIN_PROP,  24'd0, 8'd255, 8'd0,   0},
      '{1'b0, CSR_GAIN_PROP,  24'd0, 8'd200, 8'd10,  0},
      '{1'b1, CSR_OUT_MAX,    24'h00FFFF, 8'd0, 8'd0, NoCheck},
      '{1'b1, CSR_GAIN_PROP,  24'hFFFFFF, 8'd0, 8'd0, NoCheck},
      '{1'b1, CSR_GAIN_INTEG, 24'hFFFFFF, 8'd0, 8'd0, NoCheck},
      '{1'b1, CSR_GAIN_DERIV, 24'hFFFFFF, 8'd0, 8'd0, NoCheck},
      '{1'b1, CSR_DEAD_BAND,  24'hFFFF00, 8'd0, 8'd0, NoCheck}, // upper bits dropped
      '{1'b0, CSR_GAIN_PROP,  24'd0, 8'd255, 8'd0,   NoCheck},
      '{1'b0, CSR_GAIN_PROP,  24'd0, 8'd1,   8'd0,   NoCheck},
      '{1'b0, CSR_GAIN_PROP,  24'd0, 8'd0,   8'd255, NoCheck},
      '{1'b1, CsrSpareLow,    24'hFFFFFF, 8'd0, 8'd0, NoCheck}, // unmapped, ignored
      '{1'b1, CsrSpareHigh,   24'h5A5A5A, 8'd0, 8'd0, NoCheck},
      '{1'b0, CSR_GAIN_PROP,  24'd0, 8'd100, 8'd99,  NoCheck},
      '{1'b1, CSR_GAIN_PROP,  24'd0, 8'd0,   8'd0,   NoCheck},
      '{1'b1, CSR_GAIN_INTEG, 24'd0, 8'd0,   8'd0,   NoCheck},
      '{1'b1, CSR_GAIN_DERIV, 24'd0, 8'd0,   8'd0,   NoCheck},
      '{1'b1, CSR_DEAD_BAND,  24'd255, 8'd0, 8'd0,   NoCheck},
      '{1'b0, CSR_GAIN_PROP,  24'd0, 8'd255, 8'd0,   0},       // all gains zero
      '{1'b1, CSR_GAIN_INTEG, 24'd65536, 8'd0, 8'd0, NoCheck}, // integral term only
      '{1'b0, CSR_GAIN_PROP,  24'd0, 8'd17,  8'd200, NoCheck},
      '{1'b1, CSR_DEAD_BAND,  24'd0, 8'd0,   8'd0,   NoCheck},
      '{1'b1, CSR_GAIN_INTEG, 24'd0, 8'd0,   8'd0,   NoCheck},
      '{1'b1, CSR_GAIN_PROP,  24'd65536, 8'd0, 8'd0, NoCheck}, // unity P gain
      '{1'b0, CSR_GAIN_PROP,  24'd0, 8'd255, 8'd0,   255},
      '{1'b0, CSR_GAIN_PROP,  24'd0, 8'd0,   8'd255, 0},
      '{1'b0, CSR_GAIN_PROP,  24'd0, 8'd200, 8'd100, 100},
      '{1'b1, CSR_GAIN_PROP,  GainPropReset,  8'd0, 8'd0, NoCheck},
      '{1'b1, CSR_GAIN_INTEG, GainIntegReset, 8'd0, 8'd0, NoCheck},
      '{1'b1, CSR_GAIN_DERIV, GainDerivReset, 8'd0, 8'd0, NoCheck},
      '{1'b1, CSR_DEAD_BAND,  CsrDataWidth'(DeadBandReset), 8'd0, 8'd0, NoCheck},
      '{1'b1, CSR_OUT_MAX,    CsrDataWidth'(OutMaxReset),   8'd0, 8'd0, NoCheck}
   };

   logic clock;
   logic reset;

   pspl_req_if req_bus ();
   pspl_rsp_if rsp_bus ();
   pspl_csr_if csr_bus ();

   positional_pid_speed_loop u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // Register copy and loop state of the PID model
   logic [GainWidth-1:0]  ctl_gain_prop  = GainPropReset;
   logic [GainWidth-1:0]  ctl_gain_integ = GainIntegReset;
   logic [GainWidth-1:0]  ctl_gain_deriv = GainDerivReset;
   logic [BandWidth-1:0]  ctl_dead_band  = DeadBandReset;
   logic [DriveWidth-1:0] ctl_out_max    = OutMaxReset;
   int                    loop_prev_err  = 0;
   int                    loop_integral  = 0;

   logic [DriveWidth-1:0] pending_drives [$];
   reg_write_type         pending_writes [$];
   int                    req_typed;      // typed drive that rides with the beat on offer
   int                    fail_count = 0;
   int                    cycle_count = 0;
   bit                    no_gaps = 1'b0;
   bit                    choke_rsp = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // One control tick: dead band, saturating integral, derivative, Q.16 sum, clamp
   function automatic logic [DriveWidth-1:0] pid_tick(input logic [CountWidth-1:0] tgt,
                                                       input logic [CountWidth-1:0] meas);
      int     err;
      int     deriv;
      longint acc;
      longint sum;
      longint whole;
      err = int'(tgt) - int'(meas);
      if ((err < 0 ? -err : err) <= int'(ctl_dead_band)) err = 0;
      // saturation needs millions of same-sign ticks; modeled all the same
      acc = longint'(loop_integral) + longint'(err);
      if (acc > IntegTop) acc = IntegTop;
      if (acc < IntegBottom) acc = IntegBottom;
      loop_integral = int'(acc);
      deriv = err - loop_prev_err;
      loop_prev_err = err;
      sum = longint'(ctl_gain_prop) * longint'(err)
          + longint'(ctl_gain_integ) * longint'(loop_integral)
          + longint'(ctl_gain_deriv) * longint'(deriv);
      if (sum <= 0) return '0;
      whole = sum >>> 16;
      if (whole > longint'(ctl_out_max)) whole = longint'(ctl_out_max);
      return DriveWidth'(whole);
   endfunction

   function automatic logic [CountWidth-1:0] clamp_count(input int v);
      if (v < 0) return '0;
      if (v > 255) return '1;
      return CountWidth'(v);
   endfunction

   function automatic void queue_write(input logic [CsrIndexWidth-1:0] idx,
                                       input logic [CsrDataWidth-1:0] data);
      reg_write_type w;
      w.idx  = idx;
      w.data = data;
      pending_writes.push_back(w);
   endfunction

   function automatic logic [GainWidth-1:0] pick_gain();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: return '0;
         1: return '1;
         2, 3: return GainWidth'($urandom);
         default: return GainWidth'($urandom_range(0, 786432));   // up to 12.0
      endcase
   endfunction

   // Sender gap: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Offer one input beat and hold it until taken
   task automatic send_beat(input logic [CountWidth-1:0] tgt,
                            input logic [CountWidth-1:0] meas, input int typed);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.target   <= tgt;
      req_bus.measured <= meas;
      req_typed        <= typed;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Let the loop drain, then issue the queued register writes back to back
   task automatic flush_regs();
      reg_write_type w;
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_drives.size() != 0);
      while (pending_writes.size() != 0) begin
         w = pending_writes.pop_front();
         csr_bus.valid <= 1'b1;
         csr_bus.index <= w.idx;
         csr_bus.data  <= w.data;
         do @(posedge clock); while (!csr_bus.ready);
      end
      csr_bus.valid <= 1'b0;
   endtask

   // Result side: random ready spans, plus one long hold-off on request
   initial begin : rsp_side
      int span;
      int mode;
      rsp_bus.ready = 1'b0;
      forever begin
         if (choke_rsp) begin
            rsp_bus.ready <= 1'b0;
            repeat (ChokeCycles) @(posedge clock);
            choke_rsp = 1'b0;
         end else begin
            mode = $urandom_range(0, 9);
            span = $urandom_range(1, 40);
            repeat (span) begin
               case (mode)
                  0, 1, 2, 3: rsp_bus.ready <= 1'b1;
                  4, 5, 6: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
                  7, 8: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
                  default: rsp_bus.ready <= 1'b0;
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // Beat monitor: register writes, expectations, result checks
   always @(posedge clock) begin
      logic [DriveWidth-1:0] nxt;
      logic [DriveWidth-1:0] oldest;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_index_type'(csr_bus.index))
               CSR_GAIN_PROP:  ctl_gain_prop  = csr_bus.data;
               CSR_GAIN_INTEG: ctl_gain_integ = csr_bus.data;
               CSR_GAIN_DERIV: ctl_gain_deriv = csr_bus.data;
               CSR_DEAD_BAND:  ctl_dead_band  = csr_bus.data[BandWidth-1:0];
               CSR_OUT_MAX:    ctl_out_max    = csr_bus.data[DriveWidth-1:0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            nxt = pid_tick(req_bus.target, req_bus.measured);
            if (req_typed != NoCheck) nxt = DriveWidth'(req_typed);
            pending_drives.push_back(nxt);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_drives.size() == 0) begin
               $display("%0t: unexpected drive beat, expected none, actual %0d",
                        $time, rsp_bus.drive);
               fail_count++;
            end else begin
               oldest = pending_drives.pop_front();
               if (rsp_bus.drive !== oldest) begin
                  $display("%0t: drive mismatch, expected %0d, actual %0d",
                           $time, oldest, rsp_bus.drive);
                  fail_count++;
               end
            end
         end
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("%0t: timeout with %0d drives outstanding", $time, pending_drives.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // Stimulus
   initial begin
      int phase;
      int sent;
      int k;
      int n;
      int tgt;
      int m;
      int step;
      int spread;
      int noise;
      bit drained;

      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.target   = '0;
      req_bus.measured = '0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = '0;
      csr_bus.data     = '0;
      req_typed        = NoCheck;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      for (k = 0; k < DirRowCount; k++) begin
         if (dir_rows[k].is_reg) begin
            queue_write(dir_rows[k].idx, dir_rows[k].data);
         end else begin
            if (pending_writes.size() != 0) flush_regs();
            send_beat(dir_rows[k].tgt, dir_rows[k].meas, dir_rows[k].drive);
         end
      end

      // Random phases, each under its own register setting
      for (phase = 0; phase < Phases; phase++) begin
         if (phase != 0) begin
            queue_write(CSR_GAIN_PROP, pick_gain());
            queue_write(CSR_GAIN_INTEG, pick_gain());
            queue_write(CSR_GAIN_DERIV, pick_gain());
            case ($urandom_range(0, 5))
               0: n = 0;
               1: n = 255;
               2: n = $urandom_range(0, 255);
               default: n = $urandom_range(1, 6);
            endcase
            queue_write(CSR_DEAD_BAND, {16'($urandom), 8'(n)});
            case ($urandom_range(0, 5))
               0: n = 0;
               1: n = 65535;
               2: n = $urandom_range(0, 65535);
               default: n = $urandom_range(500, 4000);
            endcase
            queue_write(CSR_OUT_MAX, {8'($urandom), 16'(n)});
            if ($urandom_range(0, 2) == 0) begin
               queue_write(CsrIndexWidth'($urandom_range(CsrSpareLow, CsrSpareHigh)),
                           CsrDataWidth'($urandom));
            end
         end
         flush_regs();
         no_gaps = (phase == 2) || (phase == 5);
         // block fills against a stalled result side while beats keep coming
         if (phase == 2) choke_rsp = 1'b1;
         sent    = 0;
         drained = 1'b0;
         while (sent < ItemsPerPhase) begin
            // sender pause until the loop is empty
            if (phase == 4 && !drained && sent >= ItemsPerPhase / 2) begin
               req_bus.valid <= 1'b0;
               do @(posedge clock); while (pending_drives.size() != 0);
               drained = 1'b1;
            end
            if ($urandom_range(0, 4) == 0) begin
               // noise: unrelated counts
               n = $urandom_range(1, 8);
               for (k = 0; k < n && sent < ItemsPerPhase; k++) begin
                  send_beat(CountWidth'($urandom), CountWidth'($urandom), NoCheck);
                  sent++;
               end
            end else begin
               // speed tracking: fixed target, measured settles and jitters around it
               tgt    = $urandom_range(0, 255);
               n      = $urandom_range(5, 40);
               spread = $urandom_range(0, 12);
               step   = $urandom_range(4, 40);
               if ($urandom_range(0, 3) == 0) m = ($urandom_range(0, 1) == 0) ? 0 : 255;
               else m = tgt;
               for (k = 0; k < n && sent < ItemsPerPhase; k++) begin
                  if (m < tgt) m = (m + step > tgt) ? tgt : m + step;
                  else if (m > tgt) m = (m - step < tgt) ? tgt : m - step;
                  noise = int'($urandom_range(0, 2 * spread)) - spread;
                  send_beat(CountWidth'(tgt), clamp_count(m + noise), NoCheck);
                  sent++;
               end
            end
         end
      end

      // Drain and finish
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_drives.size() != 0);
      repeat (TailCycles) @(posedge clock);
      if (pending_drives.size() != 0) begin
         $display("%0t: %0d drives never arrived", $time, pending_drives.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule : tb_positional_pid_speed_loop

FILE: sim.f
src/pspl_pkg.sv
src/pspl_if.sv
src/positional_pid_speed_loop.sv
tb/tb_positional_pid_speed_loop.sv
